FILE: design/kstm_pkg.sv
// shared types, constants and the key code table for the keypad translator
`timescale 1ns / 1ps

package kstm_pkg;

    // matrix and table geometry
    localparam int KEY_COUNT   = 31;
    localparam int INDEX_WIDTH = $clog2(KEY_COUNT);

    // modifier keys by table index
    localparam logic [INDEX_WIDTH-1:0] SHIFT_INDEX = INDEX_WIDTH'(29 - 1);
    localparam logic [INDEX_WIDTH-1:0] SYM_INDEX   = INDEX_WIDTH'(21 - 1);
    localparam logic [1:0]             SHIFT_BIT   = 2'b01;
    localparam logic [1:0]             SYM_BIT     = 2'b10;
    localparam logic [1:0]             NO_MOD      = 2'b00;

    // special key codes
    localparam logic [7:0] CODE_BL_TOGGLE = 8'hAB;

    // event kinds
    localparam logic OP_PRESS   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // configuration register indexes
    localparam logic REG_BL_LOW  = 1'b0;
    localparam logic REG_BL_HIGH = 1'b1;

    // configuration reset values
    localparam logic [7:0] BL_LOW_RESET  = 8'd40;
    localparam logic [7:0] BL_HIGH_RESET = 8'd127;

    // one row per key: plain in [23:16], shifted in [15:8], symbol in [7:0]
    localparam logic [23:0] CODE_TABLE [KEY_COUNT] = '{
        "qQ1", "wW2", "eE3", "rR4", "tT5", "yY6", "uU7", "iI8", "oO9", "pP0",
        "aA*", "sS/", "dD+", "fF-", "gG=", "hH:", "jJ'",
        {8'h6B, 8'h4B, 8'h22},
        "lL@",
        {8'h0D, 8'h00, 8'h09},
        {8'h00, 8'h00, 8'h00},
        "zZ_", "xX$", "cC;", "vV?", "bB!", "nN,", "mM.",
        {8'h00, 8'h00, 8'h00},
        {8'h08, 8'h00, 8'h1B},
        {8'h20, 8'h00, 8'hAB}
    };

    // one key event request
    typedef struct packed {
        logic       op;
        logic [6:0] key_number;
    } kstm_req_t;

    // one translated result
    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_code;
        logic [7:0] backlight_level;
    } kstm_result_t;

endpackage

FILE: design/kstm_core.sv
// key state, sticky modifier logic, code lookup and backlight stepping
`timescale 1ns / 1ps

module kstm_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_addr,
    input  logic [7:0]            cfg_wdata,
    input  logic                  req_accept,
    input  kstm_pkg::kstm_req_t   req,
    output kstm_pkg::kstm_result_t result
);
    import kstm_pkg::*;

    logic [7:0]             bl_low_reg;
    logic [7:0]             bl_high_reg;
    logic [KEY_COUNT-1:0]   held_keys_reg;
    logic [KEY_COUNT-1:0]   held_keys_next;
    logic [4:0]             held_count_reg;
    logic [4:0]             held_count_next;
    logic [1:0]             modifier_bits_reg;
    logic [1:0]             modifier_bits_next;
    logic                   lone_modifier_reg;
    logic                   lone_modifier_next;
    logic                   persisted_reg;
    logic                   persisted_next;
    logic [7:0]             brightness_reg;
    logic [7:0]             brightness_next;

    logic                   key_ok;
    logic [INDEX_WIDTH-1:0] idx;
    logic                   is_held;
    logic [1:0]             mod;
    logic [23:0]            code_row;
    logic [7:0]             code;
    logic                   char_valid;
    logic [7:0]             char_code;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bl_low_reg  <= BL_LOW_RESET;
            bl_high_reg <= BL_HIGH_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_BL_LOW:  bl_low_reg  <= cfg_wdata;
                REG_BL_HIGH: bl_high_reg <= cfg_wdata;
                default:     bl_low_reg  <= bl_low_reg;
            endcase
        end
    end

    // key decode: keys 1..31 map straight to index key - 1
    assign key_ok  = (req.key_number != 7'd0) && (req.key_number <= 7'(KEY_COUNT));
    assign idx     = INDEX_WIDTH'(req.key_number - 7'd1);
    assign is_held = held_keys_reg[idx];

    always_comb
    begin
        priority if (idx == SHIFT_INDEX)
            mod = SHIFT_BIT;
        else if (idx == SYM_INDEX)
            mod = SYM_BIT;
        else
            mod = NO_MOD;
    end

    // column select is modifier bits mod 3, so both modifiers pick plain
    assign code_row = CODE_TABLE[idx];
    always_comb
    begin
        unique case (modifier_bits_reg)
            SHIFT_BIT: code = code_row[15:8];
            SYM_BIT:   code = code_row[7:0];
            default:   code = code_row[23:16];
        endcase
    end

    // next state for one key event
    always_comb
    begin
        held_keys_next     = held_keys_reg;
        held_count_next    = held_count_reg;
        modifier_bits_next = modifier_bits_reg;
        lone_modifier_next = lone_modifier_reg;
        persisted_next     = persisted_reg;
        brightness_next    = brightness_reg;
        char_valid         = 1'b0;
        char_code          = 8'd0;

        if (key_ok)
        begin
            if (req.op == OP_PRESS)
            begin
                if (!is_held)
                begin
                    held_keys_next[idx] = 1'b1;
                    held_count_next     = held_count_reg + 5'd1;
                    lone_modifier_next  = (mod != NO_MOD) && (held_count_next == 5'd1);
                    modifier_bits_next  = modifier_bits_reg | mod;
                end
            end
            else if (is_held)
            begin
                // backlight toggle steps 0 -> low -> high -> 0
                if (code == CODE_BL_TOGGLE)
                begin
                    priority if (brightness_reg == 8'd0)
                        brightness_next = bl_low_reg;
                    else if (brightness_reg == bl_low_reg)
                        brightness_next = bl_high_reg;
                    else if (brightness_reg >= bl_high_reg)
                        brightness_next = 8'd0;
                    else
                        brightness_next = brightness_reg;
                end
                else
                begin
                    char_valid = 1'b1;
                    char_code  = code;
                end

                held_keys_next[idx] = 1'b0;
                held_count_next     = held_count_reg - 5'd1;

                // sticky one-shot: a lone modifier tap latches, a second tap clears
                if (lone_modifier_reg)
                begin
                    lone_modifier_next = 1'b0;
                    if (persisted_reg)
                        modifier_bits_next = NO_MOD;
                    persisted_next = !persisted_reg;
                end
                else if (persisted_reg && (held_count_next == 5'd0))
                begin
                    modifier_bits_next = NO_MOD;
                    persisted_next     = 1'b0;
                end
                else
                begin
                    modifier_bits_next = modifier_bits_reg & ~mod;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_keys_reg     <= '0;
            held_count_reg    <= 5'd0;
            modifier_bits_reg <= NO_MOD;
            lone_modifier_reg <= 1'b0;
            persisted_reg     <= 1'b0;
            brightness_reg    <= 8'd0;
        end
        else if (req_accept)
        begin
            held_keys_reg     <= held_keys_next;
            held_count_reg    <= held_count_next;
            modifier_bits_reg <= modifier_bits_next;
            lone_modifier_reg <= lone_modifier_next;
            persisted_reg     <= persisted_next;
            brightness_reg    <= brightness_next;
        end
    end

    assign result.char_valid      = char_valid;
    assign result.char_code       = char_code;
    assign result.backlight_level = brightness_next;

endmodule

FILE: design/kstm_skid.sv
// two-entry output buffer between the translator logic and the result stream
`timescale 1ns / 1ps

module kstm_skid (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  kstm_pkg::kstm_result_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output kstm_pkg::kstm_result_t out_data
);
    import kstm_pkg::*;

    logic         main_valid_reg;
    logic         main_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    kstm_result_t main_data_reg;
    kstm_result_t main_data_next;
    kstm_result_t skid_data_reg;
    kstm_result_t skid_data_next;
    logic         push;
    logic         pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    // main holds the oldest result, skid catches one more while main stalls
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_valid_next = 1'b1;
                main_data_next  = in_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

FILE: design/keypad_sticky_modifier_translator_top.sv
// top level of the keypad sticky-modifier translator
`timescale 1ns / 1ps

// Keypad translator: one key event in, one result out.
// Input stream (s_*): s_tuser[0] is press (0) or release (1), s_tdata[6:0]
// is the raw key number. Output stream (m_*): m_tuser[0] is char_valid,
// m_tdata carries the character code and the backlight level after the event.
// Configuration: cfg_wr_en writes cfg_wdata to the register at cfg_addr
// (0 low backlight level, 1 high backlight level); write only while idle.
// Each result is registered in the output buffer, in main or, while main stalls, in skid.
// Throughput: one request per cycle while s_tready is high; the key state update is a single
// combinational pass from the request into the state and result registers.
// Stall: a two-entry output buffer lets one more request in while a result
// waits; s_tready drops only when both entries are full, so it does not
// depend combinationally on m_tready.
// Reset: all keys released, modifiers off, backlight off, levels 40 and 127,
// output buffer empty.
module keypad_sticky_modifier_translator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [6:0] key_number, [7] zero fill
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] char_code, [15:8] backlight_level
    output logic [0:0]  m_tuser,   // [0] char_valid
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import kstm_pkg::*;

    kstm_req_t    req;
    kstm_result_t core_result;
    kstm_result_t out_result;
    logic         req_accept;

    assign req.op         = s_tuser[0];
    assign req.key_number = s_tdata[6:0];
    assign req_accept     = s_tvalid && s_tready;

    // key state and translation
    kstm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .req_accept (req_accept),
        .req        (req),
        .result     (core_result)
    );

    // result buffer
    kstm_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {out_result.backlight_level, out_result.char_code};
    assign m_tuser = out_result.char_valid;

endmodule

FILE: design/kstm_checker.sv
// port-level checks for the keypad translator, bound to the top level
`timescale 1ns / 1ps

module kstm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // the input side only backs up when a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("request refused with empty output");

    // a request into an empty buffer shows up on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
        else $error("result missing one cycle after request");

    // no character means a zero code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
        else $error("nonzero code without char_valid");

endmodule

bind keypad_sticky_modifier_translator_top kstm_checker u_kstm_checker (.*);
